// ===== rtl/bpi_pkg.sv =====
// Shared types, codes and saturating helpers for the bounded point integrator.
package bpi_pkg;

  localparam int DIMS_DEFAULT = 4;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;
  localparam int Q_CNT_W      = 2;

  localparam logic [1:0] ACT_INTEGRATE = 2'd0;
  localparam logic [1:0] ACT_BOUND     = 2'd1;
  localparam logic [1:0] ACT_LOAD      = 2'd2;

  localparam logic [2:0] MODE_CLAMP  = 3'd0;
  localparam logic [2:0] MODE_WRAP   = 3'd1;
  localparam logic [2:0] MODE_BOUNCE = 3'd2;

  localparam logic [2:0] REG_POS_FLOOR = 3'd0;
  localparam logic [2:0] REG_POS_CEIL  = 3'd1;
  localparam logic [2:0] REG_VEL_FLOOR = 3'd2;
  localparam logic [2:0] REG_VEL_CEIL  = 3'd3;
  localparam logic [2:0] REG_ACC_FLOOR = 3'd4;
  localparam logic [2:0] REG_ACC_CEIL  = 3'd5;
  localparam logic [2:0] REG_MODES     = 3'd6;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         sel;
    logic signed [31:0] scale;
    logic signed [31:0] np;
    logic signed [31:0] nv;
    logic signed [31:0] na;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_lo;
    logic signed [31:0] pos_hi;
    logic signed [31:0] vel_lo;
    logic signed [31:0] vel_hi;
    logic signed [31:0] acc_lo;
    logic signed [31:0] acc_hi;
    logic [17:0]        modes;
  } bnd_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic               clamp;
    logic               bounce;
  } chk_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    return sat34(-34'(v));
  endfunction

  // One side of a bound test: floor when is_lo, ceiling otherwise.
  function automatic chk_t check_side(input logic signed [31:0] x,
                                      input logic signed [31:0] bnd,
                                      input logic signed [31:0] oth,
                                      input logic [2:0]         mode,
                                      input logic               is_lo);
    chk_t r;
    logic hit;
    r.x      = x;
    r.clamp  = 1'b0;
    r.bounce = 1'b0;
    hit = is_lo ? (x < bnd) : (x > bnd);
    if (hit) begin
      case (mode)
        MODE_CLAMP: begin
          r.x     = bnd;
          r.clamp = 1'b1;
        end
        MODE_WRAP: begin
          r.x = sat34(34'(oth) + 34'(x) - 34'(bnd));
        end
        MODE_BOUNCE: begin
          r.x      = sat34((34'(bnd) <<< 1) - 34'(x));
          r.bounce = 1'b1;
        end
        default: begin
          r.x = x;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/bpi_if.sv =====
// Valid/ready channel interfaces for input items and result words.
interface bpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [1:0]         dim_select;
  logic signed [31:0] step_scale;
  logic signed [31:0] new_position;
  logic signed [31:0] new_velocity;
  logic signed [31:0] new_accel;

  modport source (output valid, action, dim_select, step_scale, new_position,
                  new_velocity, new_accel, input ready);
  modport sink   (input valid, action, dim_select, step_scale, new_position,
                  new_velocity, new_accel, output ready);
endinterface

interface bpi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         dim_out;
  logic signed [31:0] position_out;
  logic signed [31:0] velocity_out;
  logic signed [31:0] accel_out;
  logic               last;

  modport source (output valid, dim_out, position_out, velocity_out, accel_out, last,
                  input ready);
  modport sink   (input valid, dim_out, position_out, velocity_out, accel_out, last,
                  output ready);
endinterface

// ===== rtl/bpi_front.sv =====
// Front end: accepts words, drops no-op actions and out-of-range loads, queues commands.
module bpi_front #(
  parameter int DIMS = bpi_pkg::DIMS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  bpi_in_if.sink         in_ch,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output bpi_pkg::cmd_t  cmd
);
  import bpi_pkg::*;

  cmd_t                q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic                keep, push, pop;
  cmd_t                in_cmd;

  assign in_ch.ready = (count_r != Q_CNT_W'(Q_DEPTH));

  always_comb begin
    case (in_ch.action)
      ACT_INTEGRATE: keep = 1'b1;
      ACT_BOUND:     keep = 1'b1;
      ACT_LOAD:      keep = (32'(in_ch.dim_select) < DIMS);
      default:       keep = 1'b0;
    endcase
  end

  assign in_cmd.op    = in_ch.action;
  assign in_cmd.sel   = in_ch.dim_select;
  assign in_cmd.scale = in_ch.step_scale;
  assign in_cmd.np    = in_ch.new_position;
  assign in_cmd.nv    = in_ch.new_velocity;
  assign in_cmd.na    = in_ch.new_accel;

  assign push      = in_ch.valid && in_ch.ready && keep;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= in_cmd;
  end

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// ===== rtl/bpi_back.sv =====
// Back end: per-dimension sequencer for integrate, bound check and load.
module bpi_back #(
  parameter int DIMS = bpi_pkg::DIMS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bpi_pkg::cmd_t  cmd,
  input  bpi_pkg::bnd_t  bnd,
  bpi_out_if.source      out_ch
);
  import bpi_pkg::*;

  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_INC   = 4'd3;
  localparam logic [3:0] S_VADD  = 4'd4;
  localparam logic [3:0] S_PADD  = 4'd5;
  localparam logic [3:0] S_PLO   = 4'd6;
  localparam logic [3:0] S_PHI   = 4'd7;
  localparam logic [3:0] S_PFX   = 4'd8;
  localparam logic [3:0] S_VLO   = 4'd9;
  localparam logic [3:0] S_VHI   = 4'd10;
  localparam logic [3:0] S_VFX   = 4'd11;
  localparam logic [3:0] S_ALO   = 4'd12;
  localparam logic [3:0] S_AHI   = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0]         state_r;
  logic [DIM_W-1:0]   dim_r;
  logic [1:0]         op_r;
  logic signed [31:0] scale_r;
  logic signed [31:0] p_r, v_r, a_r, inc_r;
  logic signed [63:0] prod_r;
  logic               clamp_r, bounce_r;
  logic signed [31:0] pos_mem [DIMS];
  logic signed [31:0] vel_mem [DIMS];
  logic signed [31:0] acc_mem [DIMS];

  logic               out_valid_r, out_last_r;
  logic [1:0]         out_dim_r;
  logic signed [31:0] out_p_r, out_v_r, out_a_r;

  logic               emit_go, lst;
  logic signed [47:0] q;
  logic signed [31:0] inc_sat;
  logic signed [31:0] cx, cb, co;
  logic [2:0]         cm;
  logic               clo;
  chk_t               chk;

  assign cmd_ready = (state_r == S_IDLE);
  assign emit_go   = !out_valid_r || out_ch.ready;
  assign lst       = (op_r == ACT_LOAD) || (dim_r == DIM_W'(DIMS - 1));

  assign q = prod_r[63:16];
  always_comb begin
    if (q > 48'sh0000_7FFF_FFFF)       inc_sat = 32'sh7FFF_FFFF;
    else if (q < -48'sh0000_8000_0000) inc_sat = 32'sh8000_0000;
    else                               inc_sat = q[31:0];
  end

  always_comb begin
    cx  = p_r;
    cb  = bnd.pos_lo;
    co  = bnd.pos_hi;
    cm  = bnd.modes[2:0];
    clo = 1'b1;
    case (state_r)
      S_PHI: begin
        cb = bnd.pos_hi; co = bnd.pos_lo; cm = bnd.modes[5:3]; clo = 1'b0;
      end
      S_VLO: begin
        cx = v_r; cb = bnd.vel_lo; co = bnd.vel_hi; cm = bnd.modes[8:6];
      end
      S_VHI: begin
        cx = v_r; cb = bnd.vel_hi; co = bnd.vel_lo; cm = bnd.modes[11:9]; clo = 1'b0;
      end
      S_ALO: begin
        cx = a_r; cb = bnd.acc_lo; co = bnd.acc_hi; cm = bnd.modes[14:12];
      end
      S_AHI: begin
        cx = a_r; cb = bnd.acc_hi; co = bnd.acc_lo; cm = bnd.modes[17:15]; clo = 1'b0;
      end
      default: begin
        cx = p_r;
      end
    endcase
  end

  assign chk = check_side(cx, cb, co, cm, clo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= '0;
      op_r        <= ACT_INTEGRATE;
      for (int i = 0; i < DIMS; i++) begin
        pos_mem[i] <= '0;
        vel_mem[i] <= '0;
        acc_mem[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            op_r    <= cmd.op;
            scale_r <= cmd.scale;
            if (cmd.op == ACT_LOAD) begin
              dim_r   <= DIM_W'(cmd.sel);
              p_r     <= cmd.np;
              v_r     <= cmd.nv;
              a_r     <= cmd.na;
              state_r <= S_EMIT;
            end else begin
              dim_r   <= '0;
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          p_r     <= pos_mem[dim_r];
          v_r     <= vel_mem[dim_r];
          a_r     <= acc_mem[dim_r];
          state_r <= (op_r == ACT_BOUND) ? S_PLO : S_MUL;
        end
        S_MUL: begin
          prod_r  <= a_r * scale_r;
          state_r <= S_INC;
        end
        S_INC: begin
          inc_r   <= inc_sat;
          state_r <= S_VADD;
        end
        S_VADD: begin
          v_r     <= sat34(34'(v_r) + 34'(inc_r));
          state_r <= S_PADD;
        end
        S_PADD: begin
          p_r     <= sat34(34'(p_r) + 34'(v_r));
          state_r <= S_EMIT;
        end
        S_PLO: begin
          p_r      <= chk.x;
          clamp_r  <= chk.clamp;
          bounce_r <= chk.bounce;
          state_r  <= S_PHI;
        end
        S_PHI: begin
          p_r      <= chk.x;
          clamp_r  <= clamp_r | chk.clamp;
          bounce_r <= bounce_r | chk.bounce;
          state_r  <= S_PFX;
        end
        S_PFX: begin
          if (bounce_r) begin
            v_r <= neg_sat(v_r);
            a_r <= neg_sat(a_r);
          end
          state_r <= S_VLO;
        end
        S_VLO: begin
          v_r      <= chk.x;
          clamp_r  <= chk.clamp;
          bounce_r <= chk.bounce;
          state_r  <= S_VHI;
        end
        S_VHI: begin
          v_r      <= chk.x;
          clamp_r  <= clamp_r | chk.clamp;
          bounce_r <= bounce_r | chk.bounce;
          state_r  <= S_VFX;
        end
        S_VFX: begin
          if (clamp_r)       a_r <= '0;
          else if (bounce_r) a_r <= neg_sat(a_r);
          state_r <= S_ALO;
        end
        S_ALO: begin
          a_r     <= chk.x;
          state_r <= S_AHI;
        end
        S_AHI: begin
          a_r     <= chk.x;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            pos_mem[dim_r] <= p_r;
            vel_mem[dim_r] <= v_r;
            acc_mem[dim_r] <= a_r;
            if (lst) begin
              state_r <= S_IDLE;
            end else begin
              dim_r   <= dim_r + 1'b1;
              state_r <= S_FETCH;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && emit_go) begin
      out_dim_r  <= 2'(dim_r);
      out_p_r    <= p_r;
      out_v_r    <= v_r;
      out_a_r    <= a_r;
      out_last_r <= lst;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dim_out      = out_dim_r;
  assign out_ch.position_out = out_p_r;
  assign out_ch.velocity_out = out_v_r;
  assign out_ch.accel_out    = out_a_r;
  assign out_ch.last         = out_last_r;

  a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dim_r) < DIMS)
    else $error("dimension index out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_go && lst) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("final word did not end the action");

endmodule

// ===== rtl/bounded_point_integrator_core.sv =====
// Top level of the bounded point integrator: configuration registers and the two halves.
//
// Usage:
//   in_ch  : input words (action, dim_select, step_scale, new_*), valid/ready.
//   out_ch : result words, one per dimension visited, last set on the final one.
//   cfg_*  : write-only register port, index 0..6; user must write only while idle, not enforced by the block.
// An accepted word enters a two-entry command queue; integrate and bound
// actions walk every dimension, load reports one dimension, and action three
// or a load beyond DIMS is dropped with no result.
// The back end takes a new command only while idle, once the previous action's final
// result is written back; per dimension, integrate steps through fetch, multiply,
// increment, velocity add, position add and emit, and bound check through fetch, the
// position and velocity floor, ceiling and fix-up steps, acceleration floor and ceiling, and emit.
// When the receiver stalls, the result register holds and the sequencer waits
// at its write-back step; the queue keeps taking words until it is full.
// Reset (synchronous, active low) zeroes point state and queue counts and restores default bounds.
module bounded_point_integrator_core #(
  parameter int DIMS = bpi_pkg::DIMS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  bpi_in_if.sink      in_ch,
  bpi_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import bpi_pkg::*;

  bnd_t bnd_r;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r.pos_lo <= -32'sd65536;
      bnd_r.pos_hi <= 32'sd65536;
      bnd_r.vel_lo <= -32'sd65536;
      bnd_r.vel_hi <= 32'sd65536;
      bnd_r.acc_lo <= -32'sd65536;
      bnd_r.acc_hi <= 32'sd65536;
      bnd_r.modes  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_FLOOR: bnd_r.pos_lo <= cfg_wdata;
        REG_POS_CEIL:  bnd_r.pos_hi <= cfg_wdata;
        REG_VEL_FLOOR: bnd_r.vel_lo <= cfg_wdata;
        REG_VEL_CEIL:  bnd_r.vel_hi <= cfg_wdata;
        REG_ACC_FLOOR: bnd_r.acc_lo <= cfg_wdata;
        REG_ACC_CEIL:  bnd_r.acc_hi <= cfg_wdata;
        REG_MODES:     bnd_r.modes  <= cfg_wdata[17:0];
        default:       bnd_r        <= bnd_r;
      endcase
    end
  end

  bpi_front #(.DIMS(DIMS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bpi_back #(.DIMS(DIMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .bnd       (bnd_r),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/bounded_point_integrator_core_test.sv =====
// Self-checking testbench for bounded_point_integrator_core: predicts every result word.
`timescale 1ns / 100ps

module bounded_point_integrator_core_test;
  import bpi_pkg::*;

  localparam int DIMS           = DIMS_DEFAULT;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] ACT_NONE  = 2'd3;
  localparam logic [2:0] MODE_IDLE = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [1:0]         dim;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               last;
  } point_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  bpi_in_if  in_ch ();
  bpi_out_if out_ch ();

  bounded_point_integrator_core #(.DIMS(DIMS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted state and bounds; index 0 position, 1 velocity, 2 acceleration
  logic signed [31:0] pos_st [DIMS];
  logic signed [31:0] vel_st [DIMS];
  logic signed [31:0] acc_st [DIMS];
  logic signed [31:0] lim_lo [3];
  logic signed [31:0] lim_hi [3];
  logic [17:0]        mode_word;

  cmd_t         pending_words [$];
  point_state_t expected_states [$];
  int           words_waiting;
  int           words_in;
  int           words_out;
  int           mismatches;
  int           settings_used;
  int           idle_cycles;
  int           burst_left;
  int           gap_left;
  int           hold_left;
  logic [8:0]   stall_tick;
  cmd_t         next_word;
  cmd_t         seen_word;
  point_state_t want;

  function automatic logic signed [31:0] clip(input longint v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] negate(input logic signed [31:0] v);
    return clip(-longint'(v));
  endfunction

  // floor then ceiling test of one quantity
  function automatic void bound_pair(inout logic signed [31:0] v, input int q,
                                     output logic clamped, output logic bounced);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [2:0]         m;
    lo = lim_lo[q];
    hi = lim_hi[q];
    clamped = 1'b0;
    bounced = 1'b0;
    if (v < lo) begin
      m = mode_word[6*q +: 3];
      case (m)
        MODE_CLAMP: begin
          v = lo;
          clamped = 1'b1;
        end
        MODE_WRAP: v = clip(longint'(hi) + longint'(v) - longint'(lo));
        MODE_BOUNCE: begin
          v = clip(2 * longint'(lo) - longint'(v));
          bounced = 1'b1;
        end
        default: ;
      endcase
    end
    if (v > hi) begin
      m = mode_word[6*q+3 +: 3];
      case (m)
        MODE_CLAMP: begin
          v = hi;
          clamped = 1'b1;
        end
        MODE_WRAP: v = clip(longint'(lo) + longint'(v) - longint'(hi));
        MODE_BOUNCE: begin
          v = clip(2 * longint'(hi) - longint'(v));
          bounced = 1'b1;
        end
        default: ;
      endcase
    end
  endfunction

  task automatic push_state(input int d);
    point_state_t s;
    s.dim  = d[1:0];
    s.pos  = pos_st[d];
    s.vel  = vel_st[d];
    s.acc  = acc_st[d];
    s.last = (d == DIMS - 1);
    expected_states.insert(expected_states.size(), s);
  endtask

  task automatic advance_points(input cmd_t c);
    longint             prod;
    logic signed [31:0] inc;
    logic               cl;
    logic               bo;
    int                 d;
    case (c.op)
      ACT_INTEGRATE: begin
        for (d = 0; d < DIMS; d++) begin
          prod = longint'(acc_st[d]) * longint'(c.scale);
          inc = clip(prod >>> 16);
          vel_st[d] = clip(longint'(vel_st[d]) + longint'(inc));
          pos_st[d] = clip(longint'(pos_st[d]) + longint'(vel_st[d]));
          push_state(d);
        end
      end
      ACT_BOUND: begin
        for (d = 0; d < DIMS; d++) begin
          bound_pair(pos_st[d], 0, cl, bo);
          if (bo) begin
            vel_st[d] = negate(vel_st[d]);
            acc_st[d] = negate(acc_st[d]);
          end
          bound_pair(vel_st[d], 1, cl, bo);
          if (cl) acc_st[d] = '0;
          if (bo) acc_st[d] = negate(acc_st[d]);
          bound_pair(acc_st[d], 2, cl, bo);
          push_state(d);
        end
      end
      ACT_LOAD: begin
        if (c.sel < DIMS) begin
          pos_st[c.sel] = c.np;
          vel_st[c.sel] = c.nv;
          acc_st[c.sel] = c.na;
          push_state(c.sel);
          expected_states[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Q16.16 value: mostly within +-4.0, sometimes full range or an extreme
  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2, 3: return $urandom;
      default: return $urandom_range(0, 524288) - 262144;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  function automatic logic [17:0] pick_modes();
    logic [17:0] m;
    int          k;
    for (k = 0; k < 6; k++)
      m[3*k +: 3] = 3'(($urandom_range(0, 4) == 0) ? $urandom_range(3, 7)
                                                   : $urandom_range(0, 2));
    return m;
  endfunction

  task automatic queue_word(input cmd_t c);
    words_waiting++;
    pending_words.insert(pending_words.size(), c);
  endtask

  task automatic queue_load(input logic [1:0] d, input logic signed [31:0] p, v, a);
    cmd_t c;
    c.op    = ACT_LOAD;
    c.sel   = d;
    c.scale = $urandom;
    c.np    = p;
    c.nv    = v;
    c.na    = a;
    queue_word(c);
  endtask

  task automatic queue_op(input logic [1:0] act, input logic signed [31:0] s);
    cmd_t c;
    c.op    = act;
    c.sel   = 2'($urandom_range(0, 3));
    c.scale = s;
    c.np    = $urandom;
    c.nv    = $urandom;
    c.na    = $urandom;
    queue_word(c);
  endtask

  task automatic queue_random(input int n);
    int got;
    int r;
    got = 0;
    while (got < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) queue_load(2'($urandom_range(0, 3)), pick_q(), pick_q(), pick_q());
      else if (r < 65) queue_op(ACT_INTEGRATE, pick_scale());
      else if (r < 95) queue_op(ACT_BOUND, $urandom);
      else queue_op(ACT_NONE, $urandom);
      if (r < 95) got++;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (words_waiting != 0 || expected_states.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_bounds(input logic signed [31:0] pf, pc, vf, vc, af, ac,
                                input logic [17:0] m);
    logic [31:0] vals [7];
    logic [2:0]  regs [7];
    int          i;
    vals = '{pf, pc, vf, vc, af, ac, {14'd0, m}};
    regs = '{REG_POS_FLOOR, REG_POS_CEIL, REG_VEL_FLOOR, REG_VEL_CEIL,
             REG_ACC_FLOOR, REG_ACC_CEIL, REG_MODES};
    for (i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_lo = '{pf, vf, af};
    lim_hi = '{pc, vc, ac};
    mode_word = m;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_ch.action       <= next_word.op;
        in_ch.dim_select   <= next_word.sel;
        in_ch.step_scale   <= next_word.scale;
        in_ch.new_position <= next_word.np;
        in_ch.new_velocity <= next_word.nv;
        in_ch.new_accel    <= next_word.na;
        in_ch.valid        <= 1'b1;
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: free-running, coin-flip, long stalls, one-in-four
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_tick <= '0;
      hold_left = 0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: begin
          if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(1, 20);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
        default: out_ch.ready <= (stall_tick[1:0] == 2'b11);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_word.op    = in_ch.action;
      seen_word.sel   = in_ch.dim_select;
      seen_word.scale = in_ch.step_scale;
      seen_word.np    = in_ch.new_position;
      seen_word.nv    = in_ch.new_velocity;
      seen_word.na    = in_ch.new_accel;
      advance_points(seen_word);
      words_in++;
      words_waiting--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual dim %0d pos %h vel %h acc %h",
                 $time, out_ch.dim_out, out_ch.position_out, out_ch.velocity_out,
                 out_ch.accel_out);
        mismatches++;
      end else begin
        want = expected_states.pop_front();
        check_field("dim", want.dim, out_ch.dim_out);
        check_field("position", want.pos, out_ch.position_out);
        check_field("velocity", want.vel, out_ch.velocity_out);
        check_field("accel", want.acc, out_ch.accel_out);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int k;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POS_FLOOR;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INTEGRATE;
    in_ch.dim_select = '0;
    in_ch.step_scale = '0;
    in_ch.new_position = '0;
    in_ch.new_velocity = '0;
    in_ch.new_accel = '0;
    out_ch.ready = 1'b0;
    words_waiting = 0;
    words_in = 0;
    words_out = 0;
    mismatches = 0;
    settings_used = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    for (k = 0; k < DIMS; k++) begin
      pos_st[k] = '0;
      vel_st[k] = '0;
      acc_st[k] = '0;
    end
    lim_lo = '{-Q_ONE, -Q_ONE, -Q_ONE};
    lim_hi = '{Q_ONE, Q_ONE, Q_ONE};
    mode_word = '0;

    // reset bounds: clamp at +-1.0; saturation, rounding, velocity clamp
    queue_load(2'd0, Q_MAX, Q_MAX, Q_MAX);
    queue_load(2'd1, Q_MIN, Q_MIN, Q_MIN);
    queue_load(2'd2, 32'sh0000_8000, 2 * Q_ONE, -3 * Q_ONE);
    queue_load(2'd3, 32'sd1, -32'sd1, 32'sd1);
    queue_op(ACT_INTEGRATE, Q_MAX);
    queue_op(ACT_INTEGRATE, Q_MIN);
    queue_op(ACT_INTEGRATE, -32'sd1);
    queue_op(ACT_INTEGRATE, 32'sd0);
    queue_op(ACT_BOUND, 32'sd0);
    queue_op(ACT_NONE, $urandom);
    queue_load(2'd3, 3 * Q_ONE, -3 * Q_ONE, 32'sd5);
    queue_op(ACT_INTEGRATE, Q_ONE);
    queue_op(ACT_BOUND, 32'sd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait_idle();
    program_bounds(-2 * Q_ONE, 2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE,
                   {6{MODE_WRAP}});
    queue_load(2'd0, 3 * Q_ONE, Q_MIN, Q_MAX);
    queue_load(2'd1, -5 * Q_ONE, 5 * Q_ONE, -Q_ONE);
    queue_op(ACT_BOUND, 32'sd0);
    queue_random(30);

    wait_idle();
    program_bounds(-Q_ONE / 2, Q_ONE / 2, -Q_ONE / 2, Q_ONE / 2, -Q_ONE / 2, Q_ONE / 2,
                   {6{MODE_BOUNCE}});
    queue_load(2'd2, 32'sh4000_0000, 32'sh7FFF_0000, Q_MIN);
    queue_load(2'd3, -Q_ONE, Q_ONE / 4, Q_ONE);
    queue_op(ACT_BOUND, 32'sd0);
    queue_random(30);

    wait_idle();
    program_bounds(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, {6{MODE_IDLE}});
    queue_random(20);

    // floor above ceiling, large enough that wrap and bounce saturate
    wait_idle();
    program_bounds(32'sh6000_0000, -32'sh6000_0000, 32'sh6000_0000, -32'sh6000_0000,
                   32'sh6000_0000, -32'sh6000_0000,
                   {MODE_WRAP, MODE_BOUNCE, MODE_BOUNCE, MODE_WRAP, MODE_WRAP, MODE_BOUNCE});
    queue_random(25);

    wait_idle();
    program_bounds(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE,
                   {MODE_BOUNCE, MODE_WRAP, MODE_CLAMP, MODE_BOUNCE, MODE_WRAP, MODE_CLAMP});
    queue_random(25);

    for (k = 0; k < 4; k++) begin
      wait_idle();
      lo = -$urandom_range(0, 196608);
      hi = $urandom_range(0, 196608);
      if ($urandom_range(0, 3) == 0)
        program_bounds(hi, lo, pick_q(), pick_q(), lo, hi, pick_modes());
      else
        program_bounds(lo, hi, lo, hi, -$urandom_range(0, 196608), $urandom_range(0, 196608),
                       pick_modes());
      queue_random(14);
    end

    wait_idle();
    $display("%0d input words and %0d result words checked under %0d bound settings",
             words_in, words_out, settings_used + 1);
    $display("covered clamp, wrap, bounce and idle modes, inverted and extreme bounds");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
